@@ design/sha256_pkg.sv @@
// sha256_pkg: payload beat types and hash constants for the sha-256 engine
// no dependencies; used by sha256_hash_engine
`default_nettype none

package sha256_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned COUNT_W    = 61;
   localparam int unsigned ROUNDS     = 64;
   localparam int unsigned ROUND_W    = 6;
   localparam int unsigned WIN_DEPTH  = 16;
   localparam int unsigned WIB_W      = 4;
   localparam int unsigned NUM_CHAIN  = 8;
   localparam int unsigned IDX_W      = 3;

   localparam logic [WORD_W-1:0] MARKER_WORD = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic [WORD_W-1:0] INIT_HASH [NUM_CHAIN] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

`default_nettype wire

@@ design/sha256_hash_engine.sv @@
// sha256_hash_engine: streaming sha-256 with padding and digest read-out
// depends on sha256_pkg (beat types, initial hash and round constants)
//
// usage
//   req channel: one beat per 32-bit message word, first byte in bits 31:24;
//   every beat carries four bytes except the one flagged last, whose
//   byte_count (0..4, larger taken as 4) gives the valid leading bytes
//   rsp channel: after the last beat, eight beats carry the digest, word 0
//   first, with last_word high on the eighth
// compression and padding
//   a word beat is taken in ST_IDLE; the sixteenth word of a block starts a
//   compression in ST_ROUND, one round per cycle by the single round unit,
//   then the chaining add in ST_FOLD; no new word is taken until it is done
//   after the last beat the padder feeds one marker, zero or length word per
//   cycle while no compression runs, up to 18 in all, compressing wherever a block
//   fills (one or two compressions), then eight rsp beats
// reset
//   synchronous, active high: chaining words return to the initial hash,
//   byte count and block position clear, the engine sits idle and ready
// stalls
//   req_ready is low during each compression (ST_ROUND, ST_FOLD), and from the last
//   beat until the eighth digest beat is taken; a low rsp_ready simply holds
//   the current digest beat, nothing is lost
`default_nettype none

module sha256_hash_engine (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  sha256_pkg::req_type   req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output sha256_pkg::rsp_type   rsp_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;  // taking message words
   localparam logic [2:0] ST_PAD   = 3'd1;  // feeding marker, zero fill, length
   localparam logic [2:0] ST_ROUND = 3'd2;  // one compression round per cycle
   localparam logic [2:0] ST_FOLD  = 3'd3;  // add working words into the chain
   localparam logic [2:0] ST_OUT   = 3'd4;  // digest beats

   localparam int unsigned W = sha256_pkg::WORD_W;

   logic [2:0]                        state_ff, state_in;
   logic [W-1:0]                      chain_ff [sha256_pkg::NUM_CHAIN];
   logic [W-1:0]                      chain_in [sha256_pkg::NUM_CHAIN];
   logic [W-1:0]                      work_ff  [sha256_pkg::NUM_CHAIN];
   logic [W-1:0]                      work_in  [sha256_pkg::NUM_CHAIN];
   // schedule window as a shift line: entry 0 is the oldest word
   logic [W-1:0]                      win_ff   [sha256_pkg::WIN_DEPTH];
   logic [sha256_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [sha256_pkg::ROUND_W-1:0]    round_ff, round_in;
   logic [sha256_pkg::WIB_W-1:0]      wib_ff, wib_in;
   logic [sha256_pkg::IDX_W-1:0]      out_idx_ff, out_idx_in;
   logic                              pad_mode_ff, pad_mode_in;   // message closed
   logic                              need_mark_ff, need_mark_in; // marker word owed
   logic                              len_hi_ff, len_hi_in;       // upper length word sent
   logic                              len_done_ff, len_done_in;   // lower length word sent

   logic                              shift_en;
   logic [W-1:0]                      shift_word;
   logic                              push_en;
   logic [W-1:0]                      push_word;
   logic                              req_acc, rsp_acc;
   logic [2:0]                        nbytes;
   logic [W-1:0]                      tail_word;

   // round datapath
   logic [W-1:0] sum1, sum0, choose, major, t1, sched_s0, sched_s1, w_new;
   logic [W-1:0] bits_hi, bits_lo;

   function automatic logic [W-1:0] rotr(input logic [W-1:0] v, input int unsigned c);
      rotr = (v >> c) | (v << (W - c));
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_acc   = rsp_valid && rsp_ready;

   assign rsp_data.digest_word = chain_ff[out_idx_ff];
   assign rsp_data.word_index  = out_idx_ff;
   assign rsp_data.last_word   = (out_idx_ff == sha256_pkg::IDX_W'(sha256_pkg::NUM_CHAIN - 1));

   // clamp oversized counts to a full word
   assign nbytes = (req_data.byte_count > 3'd4) ? 3'd4 : req_data.byte_count;

   // short last word: keep leading bytes, marker right after them
   always_comb begin
      case (nbytes)
         3'd1:    tail_word = {req_data.data_word[31:24], 24'h80_0000};
         3'd2:    tail_word = {req_data.data_word[31:16], 16'h8000};
         3'd3:    tail_word = {req_data.data_word[31:8], 8'h80};
         default: tail_word = sha256_pkg::MARKER_WORD;
      endcase
   end

   // bit length, wraps modulo 2^64
   assign bits_hi = count_ff[sha256_pkg::COUNT_W-1 -: W];
   assign bits_lo = {count_ff[W-4:0], 3'b000};

   // compression round on working words a..h = work[0..7]
   assign sum1   = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
   assign choose = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign t1     = work_ff[7] + sum1 + choose + sha256_pkg::ROUND_K[round_ff] + win_ff[0];
   assign sum0   = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
   assign major  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                 ^ (work_ff[1] & work_ff[2]);

   // schedule expansion in parallel with the round
   assign sched_s0 = rotr(win_ff[1], 7) ^ rotr(win_ff[1], 18) ^ (win_ff[1] >> 3);
   assign sched_s1 = rotr(win_ff[14], 17) ^ rotr(win_ff[14], 19) ^ (win_ff[14] >> 10);
   assign w_new    = win_ff[0] + sched_s0 + win_ff[9] + sched_s1;

   always_comb begin
      state_in     = state_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      count_in     = count_ff;
      round_in     = round_ff;
      wib_in       = wib_ff;
      out_idx_in   = out_idx_ff;
      pad_mode_in  = pad_mode_ff;
      need_mark_in = need_mark_ff;
      len_hi_in    = len_hi_ff;
      len_done_in  = len_done_ff;
      push_en      = 1'b0;
      push_word    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               push_en = 1'b1;
               if (!req_data.last) begin
                  push_word = req_data.data_word;
                  count_in  = count_ff + sha256_pkg::COUNT_W'(4);
               end else begin
                  count_in    = count_ff + sha256_pkg::COUNT_W'(nbytes);
                  pad_mode_in = 1'b1;
                  if (nbytes == 3'd4) begin
                     push_word    = req_data.data_word;
                     need_mark_in = 1'b1;
                  end else begin
                     push_word = tail_word;
                  end
               end
            end
         end
         ST_PAD: begin
            push_en = 1'b1;
            if (need_mark_ff) begin
               push_word    = sha256_pkg::MARKER_WORD;
               need_mark_in = 1'b0;
            end else if (wib_ff == 4'd14) begin
               push_word = bits_hi;
               len_hi_in = 1'b1;
            end else if (wib_ff == 4'd15 && len_hi_ff) begin
               push_word   = bits_lo;
               len_done_in = 1'b1;
            end else begin
               push_word = '0;
            end
         end
         ST_ROUND: begin
            for (int i = 7; i > 0; i--) begin
               work_in[i] = work_ff[i-1];
            end
            work_in[4] = work_ff[3] + t1;
            work_in[0] = t1 + sum0 + major;
            round_in   = round_ff + 1'b1;
            if (round_ff == sha256_pkg::ROUND_W'(sha256_pkg::ROUNDS - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < sha256_pkg::NUM_CHAIN; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            if (len_done_ff) begin
               state_in = ST_OUT;
            end else if (pad_mode_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_acc) begin
               out_idx_in = out_idx_ff + 1'b1;
               if (rsp_data.last_word) begin
                  // re-arm for the next message
                  chain_in     = sha256_pkg::INIT_HASH;
                  count_in     = '0;
                  wib_in       = '0;
                  out_idx_in   = '0;
                  pad_mode_in  = 1'b0;
                  need_mark_in = 1'b0;
                  len_hi_in    = 1'b0;
                  len_done_in  = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a word into the block; the sixteenth starts a compression
      if (push_en) begin
         wib_in = wib_ff + 1'b1;
         if (wib_ff == 4'd15) begin
            work_in  = chain_ff;
            round_in = '0;
            state_in = ST_ROUND;
         end else if (state_ff == ST_IDLE && req_data.last) begin
            state_in = ST_PAD;
         end
      end
   end

   assign shift_en   = push_en || (state_ff == ST_ROUND);
   assign shift_word = push_en ? push_word : w_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chain_ff     <= sha256_pkg::INIT_HASH;
         count_ff     <= '0;
         round_ff     <= '0;
         wib_ff       <= '0;
         out_idx_ff   <= '0;
         pad_mode_ff  <= 1'b0;
         need_mark_ff <= 1'b0;
         len_hi_ff    <= 1'b0;
         len_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         count_ff     <= count_in;
         round_ff     <= round_in;
         wib_ff       <= wib_in;
         out_idx_ff   <= out_idx_in;
         pad_mode_ff  <= pad_mode_in;
         need_mark_ff <= need_mark_in;
         len_hi_ff    <= len_hi_in;
         len_done_ff  <= len_done_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (shift_en) begin
         for (int i = 0; i < sha256_pkg::WIN_DEPTH - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[sha256_pkg::WIN_DEPTH-1] <= shift_word;
      end
   end

endmodule

`default_nettype wire
